### sv/utfsd_pkg.sv
`timescale 1ns / 1ps

package utfsd_pkg;

   localparam int UNIT_W = 21;

   // Result queue depth: one item may push two results.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [UNIT_W-1:0] QMARK_CODE     = 21'h00003F;
   localparam logic [UNIT_W-1:0] BOM_CODE       = 21'h00FEFF;
   localparam logic [UNIT_W-1:0] SURR_HIGH_BASE = 21'h00D7C0;
   localparam logic [UNIT_W-1:0] SURR_LOW_BASE  = 21'h00DC00;

   localparam logic [2:0] SEQ_NONE  = 3'd0;
   localparam logic [2:0] SEQ_TWO   = 3'd2;
   localparam logic [2:0] SEQ_THREE = 3'd3;
   localparam logic [2:0] SEQ_FOUR  = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              bad_sequence;
      logic              run_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        bytes_pending;
      logic [UNIT_W-1:0] partial_value;
      logic [2:0]        seq_length;
      logic              at_string_start;
      logic              ignoring_rest;
   } dec_state_type;

   localparam dec_state_type DEC_STATE_RESET = '{
      bytes_pending:   2'd0,
      partial_value:   '0,
      seq_length:      SEQ_NONE,
      at_string_start: 1'b1,
      ignoring_rest:   1'b0
   };

   typedef struct packed {
      logic [1:0]    count;
      rsp_type       first;
      rsp_type       second;
      dec_state_type next_state;
   } dec_result_type;

endpackage

### sv/utfsd_decode.sv
`timescale 1ns / 1ps

module utfsd_decode import utfsd_pkg::*; (
   input  dec_state_type  state,
   input  req_type        item,
   input  logic           pair_output,
   output dec_result_type result
);

   logic [7:0]        b;
   logic              last;
   dec_state_type     nxt;
   logic [1:0]        n;
   rsp_type           r0;
   rsp_type           r1;
   logic [UNIT_W-1:0] cp;

   always_comb begin
      b    = item.in_byte;
      last = item.final_byte;
      nxt  = state;
      n    = 2'd0;
      r0   = '0;
      r1   = '0;
      cp   = {state.partial_value[UNIT_W-7:0], b[5:0]};

      if (state.ignoring_rest) begin
         n = 2'd0;
      end else if (state.bytes_pending != 2'd0) begin
         if (b == 8'd0) begin
            r0 = '{code_unit: QMARK_CODE, bad_sequence: 1'b1, run_end: 1'b0};
            n = 2'd1;
            nxt.ignoring_rest = 1'b1;
         end else begin
            nxt.partial_value = cp;
            nxt.bytes_pending = state.bytes_pending - 2'd1;
            if (state.bytes_pending == 2'd1) begin
               if (state.seq_length == SEQ_THREE) begin
                  // A byte-order mark is dropped only as the string's first unit.
                  if (!(cp == BOM_CODE && state.at_string_start)) begin
                     r0 = '{code_unit: cp, bad_sequence: 1'b0, run_end: 1'b0};
                     n = 2'd1;
                  end
               end else if (state.seq_length == SEQ_FOUR && pair_output) begin
                  r0 = '{code_unit: SURR_HIGH_BASE + {10'd0, cp[UNIT_W-1:10]},
                         bad_sequence: 1'b0, run_end: 1'b0};
                  r1 = '{code_unit: SURR_LOW_BASE | {11'd0, cp[9:0]},
                         bad_sequence: 1'b0, run_end: 1'b0};
                  n = 2'd2;
               end else begin
                  r0 = '{code_unit: cp, bad_sequence: 1'b0, run_end: 1'b0};
                  n = 2'd1;
               end
               nxt.at_string_start = 1'b0;
               nxt.seq_length      = SEQ_NONE;
               nxt.partial_value   = '0;
            end else if (last) begin
               r0 = '{code_unit: QMARK_CODE, bad_sequence: 1'b1, run_end: 1'b0};
               n = 2'd1;
            end
         end
      end else if (b == 8'd0) begin
         nxt.ignoring_rest = 1'b1;
      end else if (b[7] == 1'b0) begin
         r0 = '{code_unit: {13'd0, b}, bad_sequence: 1'b0, run_end: 1'b0};
         n = 2'd1;
         nxt.at_string_start = 1'b0;
      end else if (b[7:5] == 3'b110) begin
         nxt.partial_value = {16'd0, b[4:0]};
         nxt.bytes_pending = 2'd1;
         nxt.seq_length    = SEQ_TWO;
      end else if (b[7:4] == 4'b1110) begin
         nxt.partial_value = {17'd0, b[3:0]};
         nxt.bytes_pending = 2'd2;
         nxt.seq_length    = SEQ_THREE;
      end else if (b[7:3] == 5'b11110) begin
         nxt.partial_value = {18'd0, b[2:0]};
         nxt.bytes_pending = 2'd3;
         nxt.seq_length    = SEQ_FOUR;
      end else begin
         r0 = '{code_unit: QMARK_CODE, bad_sequence: 1'b1, run_end: 1'b0};
         n = 2'd1;
         nxt.at_string_start = 1'b0;
      end

      // A lead byte flagged as last leaves its sequence unfinished.
      if (last && n == 2'd0 && nxt.bytes_pending != 2'd0 && !nxt.ignoring_rest) begin
         r0 = '{code_unit: QMARK_CODE, bad_sequence: 1'b1, run_end: 1'b0};
         n = 2'd1;
      end

      if (n == 2'd1) begin
         r0.run_end = 1'b1;
      end else if (n == 2'd2) begin
         r1.run_end = 1'b1;
      end

      if (last) begin
         nxt = DEC_STATE_RESET;
      end

      result.count      = n;
      result.first      = r0;
      result.second     = r1;
      result.next_state = nxt;
   end

endmodule

### sv/utfsd_rsp_queue.sv
`timescale 1ns / 1ps

module utfsd_rsp_queue import utfsd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic [1:0] push_count,
   input  rsp_type  push_first,
   input  rsp_type  push_second,
   output logic     room_for_two,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_PTR_W-1:0]   wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_PTR_W-1:0]   rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff;
   logic [RSP_CNT_W-1:0]   count_in;
   logic [RSP_PTR_W-1:0]   wr_next;
   logic                   pop;

   assign pop          = out_valid && out_ready;
   assign out_valid    = (count_ff != '0);
   assign out_data     = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign wr_next      = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push_count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push_second;
      end
   end

endmodule

### sv/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Carries
// req_      in         req_valid/req_ready    req_type: one byte, last-byte flag
// rsp_      out        rsp_valid/rsp_ready    rsp_type: code unit, error mark, run end
// csr_      in         csr_valid/csr_ready    pair_output mode bit
//
// A byte is taken into an input register, decoded from there, and its
// zero, one or two results written into a four-entry result queue.
// One byte per cycle is sustained while the queue has room; both results of a
// byte go in together. The decode stage waits while the queue has fewer than
// two free entries. Synchronous reset clears the queue, the input stage and the
// decoder state; the mode bit resets to whole code points.

module utf8_stream_decoder import utfsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   logic           stage_valid_ff;
   logic           stage_valid_in;
   req_type        stage_ff;
   dec_state_type  state_ff;
   dec_state_type  state_in;
   logic           pair_output_ff;
   logic           pair_output_in;
   dec_result_type dec;
   logic           room_for_two;
   logic           advance;
   logic [1:0]     push_count;

   assign csr_ready  = 1'b1;
   assign advance    = stage_valid_ff && room_for_two;
   assign req_ready  = !stage_valid_ff || room_for_two;
   assign push_count = advance ? dec.count : 2'd0;

   utfsd_decode u_decode (
      .state       (state_ff),
      .item        (stage_ff),
      .pair_output (pair_output_ff),
      .result      (dec)
   );

   utfsd_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_first   (dec.first),
      .push_second  (dec.second),
      .room_for_two (room_for_two),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_data     (rsp_data)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      state_in       = advance ? dec.next_state : state_ff;
      pair_output_in = (csr_valid && csr_ready) ? csr_wdata : pair_output_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         state_ff       <= DEC_STATE_RESET;
         pair_output_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         state_ff       <= state_in;
         pair_output_ff <= pair_output_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= req_data;
      end
   end

endmodule

### tb/sv/utf8_stream_decoder_test.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
   import utfsd_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_TICKS = 8;
   localparam int SCRIPT_LEN   = 25;

   localparam logic [UNIT_W-1:0] NO_CODE = '0;
   localparam rsp_type NO_UNIT = '0;

   typedef struct packed {
      logic [7:0]        in_byte;
      logic              fin;
      logic              pairs;
      logic              typed;
      logic [UNIT_W-1:0] code;
      logic              bad;
   } script_row_type;

   // Directed strings. Rows with typed set carry their one result; the rest
   // are checked against the predictor.
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // Byte-order mark opening a string gives nothing.
      '{8'hEF, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'hBB, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'h01, 1'b0, 1'b0, 1'b1, 21'h000001, 1'b0},
      '{8'h7F, 1'b0, 1'b0, 1'b1, 21'h00007F, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b1, QMARK_CODE, 1'b1},
      '{8'hFF, 1'b0, 1'b0, 1'b1, QMARK_CODE, 1'b1},
      '{8'hDF, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      // A byte-order mark later in the string is a normal character.
      '{8'hEF, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'hBB, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'hF0, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'h9F, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'h98, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      // Zero byte ends the string; the flagged byte after it is dropped.
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_CODE, 1'b0},
      '{8'hC2, 1'b1, 1'b0, 1'b0, NO_CODE, 1'b0},
      // Lead byte flagged as last leaves its sequence unfinished.
      '{8'hE2, 1'b1, 1'b0, 1'b1, QMARK_CODE, 1'b1},
      '{8'hF7, 1'b0, 1'b1, 1'b0, NO_CODE, 1'b0},
      '{8'hBF, 1'b0, 1'b1, 1'b0, NO_CODE, 1'b0},
      '{8'hBF, 1'b0, 1'b1, 1'b0, NO_CODE, 1'b0},
      '{8'hBF, 1'b0, 1'b1, 1'b0, NO_CODE, 1'b0},
      '{8'hC3, 1'b0, 1'b1, 1'b0, NO_CODE, 1'b0},
      '{8'h00, 1'b1, 1'b1, 1'b1, QMARK_CODE, 1'b1}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_wdata = 1'b0;

   // Expected result for a directed row, travelling with the item.
   logic    req_typed = 1'b0;
   rsp_type req_typed_unit = '0;

   // Predictor state.
   logic              pairs_enabled = 1'b0;
   logic [1:0]        tail_count = 2'd0;
   logic [UNIT_W-1:0] code_accum = '0;
   logic [2:0]        seq_size = SEQ_NONE;
   logic              string_fresh = 1'b1;
   logic              string_closed = 1'b0;

   rsp_type expected_units [$];
   int      error_count = 0;
   int      quiet_cycles = 0;
   int      queued_before;
   int      live_bytes = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   logic    mode_setting = 1'b0;

   utf8_stream_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type make_unit(input logic [UNIT_W-1:0] code, input logic bad);
      rsp_type u;
      u.code_unit    = code;
      u.bad_sequence = bad;
      u.run_end      = 1'b0;
      return u;
   endfunction

   task automatic log_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Advances the predictor by one byte and queues the code units it yields.
   task automatic decode_byte(input logic [7:0] b, input logic fin);
      rsp_type           units [$];
      logic [UNIT_W-1:0] cp;
      units = {};
      if (string_closed) begin
      end else if (tail_count != 2'd0) begin
         if (b == 8'h00) begin
            units = {units, make_unit(QMARK_CODE, 1'b1)};
            string_closed = 1'b1;
         end else begin
            code_accum = {code_accum[UNIT_W-7:0], b[5:0]};
            tail_count = tail_count - 2'd1;
            if (tail_count == 2'd0) begin
               cp = code_accum;
               if (seq_size == SEQ_THREE) begin
                  if (!(cp == BOM_CODE && string_fresh))
                     units = {units, make_unit(cp, 1'b0)};
               end else if (seq_size == SEQ_FOUR && pairs_enabled) begin
                  units = {units, make_unit(SURR_HIGH_BASE + (cp >> 10), 1'b0)};
                  // Low half keeps the bottom ten bits of the code point.
                  units = {units, make_unit(SURR_LOW_BASE | (cp & 21'h0003FF), 1'b0)};
               end else begin
                  units = {units, make_unit(cp, 1'b0)};
               end
               string_fresh = 1'b0;
               seq_size = SEQ_NONE;
               code_accum = '0;
            end else if (fin) begin
               units = {units, make_unit(QMARK_CODE, 1'b1)};
            end
         end
      end else if (b == 8'h00) begin
         string_closed = 1'b1;
      end else if (!b[7]) begin
         units = {units, make_unit({13'd0, b}, 1'b0)};
         string_fresh = 1'b0;
      end else if (b[7:5] == 3'b110) begin
         code_accum = {16'd0, b[4:0]};
         tail_count = 2'd1;
         seq_size = SEQ_TWO;
      end else if (b[7:4] == 4'b1110) begin
         code_accum = {17'd0, b[3:0]};
         tail_count = 2'd2;
         seq_size = SEQ_THREE;
      end else if (b[7:3] == 5'b11110) begin
         code_accum = {18'd0, b[2:0]};
         tail_count = 2'd3;
         seq_size = SEQ_FOUR;
      end else begin
         units = {units, make_unit(QMARK_CODE, 1'b1)};
         string_fresh = 1'b0;
      end

      if (fin && units.size() == 0 && tail_count != 2'd0 && !string_closed)
         units = {units, make_unit(QMARK_CODE, 1'b1)};
      if (units.size() > 0)
         units[units.size() - 1].run_end = 1'b1;
      expected_units = {expected_units, units};

      if (fin) begin
         tail_count = 2'd0;
         code_accum = '0;
         seq_size = SEQ_NONE;
         string_fresh = 1'b1;
         string_closed = 1'b0;
      end
   endtask

   task automatic check_unit(input rsp_type got);
      rsp_type want;
      if (expected_units.size() == 0) begin
         log_mismatch($sformatf("unexpected code unit %h", got.code_unit));
      end else begin
         want = expected_units.pop_front();
         if (got.code_unit !== want.code_unit)
            log_mismatch($sformatf("code_unit %h, want %h", got.code_unit, want.code_unit));
         if (got.bad_sequence !== want.bad_sequence)
            log_mismatch($sformatf("bad_sequence %b, want %b (code %h)",
                                   got.bad_sequence, want.bad_sequence, want.code_unit));
         if (got.run_end !== want.run_end)
            log_mismatch($sformatf("run_end %b, want %b (code %h)",
                                   got.run_end, want.run_end, want.code_unit));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_unit(rsp_data);
         if (req_valid && req_ready) begin
            queued_before = expected_units.size();
            decode_byte(req_data.in_byte, req_data.final_byte);
            if (req_typed) begin
               while (expected_units.size() > queued_before)
                  void'(expected_units.pop_back());
               expected_units = {expected_units, req_typed_unit};
            end
         end
         if (csr_valid && csr_ready)
            pairs_enabled = csr_wdata;
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      do
         @(posedge clock);
      while (quiet_cycles < QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                            input rsp_type typed_unit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{in_byte: b, final_byte: fin};
      req_typed <= typed;
      req_typed_unit <= typed_unit;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // Holds the sender until every expected code unit is out and the
   // pipeline has had time to finish items that give none.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_units.size() != 0);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_mode(input logic pairs);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= pairs;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      mode_setting = pairs;
   endtask

   function automatic logic [7:0] tail_byte();
      if ($urandom_range(9) != 0)
         return {2'b10, 6'($urandom_range(63))};
      return 8'($urandom_range(255));
   endfunction

   // Mostly well-formed strings with random content; some noise, stray
   // continuation or invalid bytes, early zero bytes and cut-off endings.
   task automatic send_string();
      logic [7:0] string_bytes [$];
      int         points;
      int         pick;
      bit         counting;
      string_bytes = {};
      counting = 1'b1;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 8)) string_bytes = {string_bytes, 8'($urandom_range(255))};
      end else begin
         if ($urandom_range(7) == 0)
            string_bytes = {8'hEF, 8'hBB, 8'hBF};
         points = $urandom_range(1, 10);
         for (int k = 0; k < points; k++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               string_bytes = {string_bytes, 8'($urandom_range(1, 127))};
            end else if (pick < 50) begin
               string_bytes = {string_bytes, {3'b110, 5'($urandom_range(31))}};
               string_bytes = {string_bytes, tail_byte()};
            end else if (pick < 70) begin
               string_bytes = {string_bytes, {4'b1110, 4'($urandom_range(15))}};
               repeat (2) string_bytes = {string_bytes, tail_byte()};
            end else if (pick < 88) begin
               string_bytes = {string_bytes, {5'b11110, 3'($urandom_range(7))}};
               repeat (3) string_bytes = {string_bytes, tail_byte()};
            end else if (pick < 93) begin
               string_bytes = {string_bytes,
                               ($urandom_range(1) ? {2'b10, 6'($urandom_range(63))}
                                                  : {5'b11111, 3'($urandom_range(7))})};
            end else if (pick < 96) begin
               string_bytes = {string_bytes, 8'hEF, 8'hBB, 8'hBF};
            end else begin
               string_bytes = {string_bytes, 8'h00};
               repeat ($urandom_range(3))
                  string_bytes = {string_bytes, 8'($urandom_range(255))};
               break;
            end
         end
         if ($urandom_range(11) == 0 && string_bytes.size() > 1)
            void'(string_bytes.pop_back());
      end
      foreach (string_bytes[i]) begin
         if (string_bytes[i] == 8'h00)
            counting = 1'b0;
         if (counting)
            live_bytes++;
         send_byte(string_bytes[i], i == string_bytes.size() - 1, 1'b0, NO_UNIT);
      end
   endtask

   initial begin
      int target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         if (SCRIPT[i].pairs !== mode_setting)
            write_mode(SCRIPT[i].pairs);
         send_byte(SCRIPT[i].in_byte, SCRIPT[i].fin, SCRIPT[i].typed,
                   '{code_unit: SCRIPT[i].code, bad_sequence: SCRIPT[i].bad, run_end: 1'b1});
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 9;
               recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_mode(phase != 1);
         target = live_bytes + 135;
         while (live_bytes < target) begin
            if ($urandom_range(19) == 0)
               write_mode(1'($urandom_range(1)));
            else if ($urandom_range(29) == 0)
               wait_drained();
            send_string();
         end
      end

      wait_drained();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
sv/utfsd_pkg.sv
sv/utfsd_decode.sv
sv/utfsd_rsp_queue.sv
sv/utf8_stream_decoder.sv
tb/sv/utf8_stream_decoder_test.sv
